FILE: src/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
// No dependencies; every other file in src except mme_ram refers to this package by scoped name.
package mme_pkg;

    localparam int ROWS_DEFAULT  = 4;
    localparam int INNER_DEFAULT = 4;

    localparam int IDX_W  = 2;
    localparam int FUNC_W = 2;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 40;

    localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         column;
        logic signed [ELEM_W-1:0] element;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_column;
        logic signed [ACC_W-1:0] product_value;
        logic                    last;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // accepted beat is a load; datapath picks A or B and range-checks
        logic start;  // clear the entry and inner counters
        logic read;   // issue RAM reads for the current i, j, k
        logic mul;    // register the product of the read elements
        logic acc;    // add the product into the accumulator, step k
        logic emit;   // move the finished entry to the output register, step j/i
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic k_last;    // inner index is at its final value
        logic run_last;  // current entry is the final one of the run
        logic out_busy;  // output register holds a beat that is not taken this cycle
    } status_t;

endpackage

FILE: src/mme_stream_if.sv
// Valid/ready channel carrying one payload struct per beat.
// Depends on mme_pkg for the default payload type.
interface mme_stream_if #(
    parameter type payload_t = mme_pkg::in_item_t
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/mme_ctrl.sv
// Sequencer for the matrix multiply engine: accepts beats and steps the datapath.
// Depends on mme_pkg (command/status structs, function codes) and mme_stream_if.
module mme_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    mme_stream_if.sink        request,
    input  mme_pkg::status_t  status,
    output mme_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_ACC  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.data.func)
                        mme_pkg::FUNC_WRITE_A,
                        mme_pkg::FUNC_WRITE_B:
                        begin
                            cmd.load = 1'b1;
                        end
                        mme_pkg::FUNC_COMPUTE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            // Unused function code: the beat is dropped.
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.k_last ? S_EMIT : S_READ;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.run_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/mme_datapath.sv
// Matrix storage, multiply-accumulate unit, index counters and output register.
// Depends on mme_pkg, mme_stream_if and mme_ram.
module mme_datapath #(
    parameter int ROWS  = mme_pkg::ROWS_DEFAULT,
    parameter int INNER = mme_pkg::INNER_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mme_pkg::in_item_t item,
    input  mme_pkg::cmd_t     cmd,
    output mme_pkg::status_t  status,
    mme_stream_if.source      result
);

    localparam int DEPTH = ROWS * INNER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW    = (INNER > 1) ? $clog2(INNER) : 1;

    logic [RW-1:0] i_reg;
    logic [RW-1:0] j_reg;
    logic [KW-1:0] k_reg;

    logic                 we_a;
    logic                 we_b;
    logic [AW-1:0]        waddr_a;
    logic [AW-1:0]        waddr_b;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;
    logic [mme_pkg::ELEM_W-1:0] rdata_a;
    logic [mme_pkg::ELEM_W-1:0] rdata_b;

    logic signed [mme_pkg::PROD_W-1:0] prod_reg;
    logic signed [mme_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mme_pkg::ACC_W-1:0]  acc_next;

    logic              out_valid_reg;
    mme_pkg::out_item_t out_data_reg;

    logic k_last;
    logic j_last;
    logic run_last;

    assign k_last   = (k_reg == KW'(INNER - 1));
    assign j_last   = (j_reg == RW'(ROWS - 1));
    assign run_last = j_last && (i_reg == RW'(ROWS - 1));

    // A is ROWS by INNER, B is INNER by ROWS; out-of-range writes are dropped.
    assign we_a = cmd.load && (item.func == mme_pkg::FUNC_WRITE_A)
                  && (int'(item.row) < ROWS) && (int'(item.column) < INNER);
    assign we_b = cmd.load && (item.func == mme_pkg::FUNC_WRITE_B)
                  && (int'(item.row) < INNER) && (int'(item.column) < ROWS);

    assign waddr_a = AW'(int'(item.row) * INNER + int'(item.column));
    assign waddr_b = AW'(int'(item.row) * ROWS + int'(item.column));
    assign raddr_a = AW'(int'(i_reg) * INNER + int'(k_reg));
    assign raddr_b = AW'(int'(k_reg) * ROWS + int'(j_reg));

    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (item.element),
        .re    (cmd.read),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (item.element),
        .re    (cmd.read),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= $signed(rdata_a) * $signed(rdata_b);
        end
    end

    // The first product of an entry replaces the running sum.
    assign acc_next = ((k_reg == '0) ? '0 : acc_reg) + mme_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                acc_reg <= acc_next;
                k_reg   <= k_last ? '0 : k_reg + KW'(1);
            end
            if (cmd.start)
            begin
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
            end
            else if (cmd.emit)
            begin
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + RW'(1);
                end
                else
                begin
                    j_reg <= j_reg + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.out_row       <= mme_pkg::IDX_W'(i_reg);
            out_data_reg.out_column    <= mme_pkg::IDX_W'(j_reg);
            out_data_reg.product_value <= acc_reg;
            out_data_reg.last          <= run_last;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign status.k_last   = k_last;
    assign status.run_last = run_last;
    assign status.out_busy = out_valid_reg && !result.ready;

endmodule

FILE: src/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: sequencer plus datapath.
// Depends on mme_pkg, mme_stream_if, mme_ram, mme_ctrl and mme_datapath.
//
//   Channel   Direction  Payload              Beat
//   request   sink       mme_pkg::in_item_t   one load or one compute command
//   result    source     mme_pkg::out_item_t  one product entry, last on the final one
//
// A load beat is taken while the engine is idle; loads may come back to back.
// A compute beat runs ROWS*ROWS entries, each INNER passes through the read,
// multiply and accumulate states, which the registered RAM read and the product
// register set apart, then an emit state that hands the entry to the output register.
// A held result beat stalls the run at that hand-off; no request is taken
// during a run. Reset clears control state; matrix contents are not cleared.
module matrix_multiply_engine #(
    parameter int ROWS  = mme_pkg::ROWS_DEFAULT,
    parameter int INNER = mme_pkg::INNER_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    mme_stream_if.sink   request,
    mme_stream_if.source result
);

    mme_pkg::cmd_t    cmd;
    mme_pkg::status_t status;

    mme_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .status  (status),
        .cmd     (cmd)
    );

    mme_datapath #(
        .ROWS  (ROWS),
        .INNER (INNER)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (request.data),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

`ifndef ASSERT_OFF
    // A finished entry never overwrites a result beat that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_busy)
        else $error("entry emitted over a held result beat");

    // A compute beat starts the first element read in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> cmd.read)
        else $error("compute run did not start reading");

    // Matrix loads never land while a run is reading or accumulating.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(cmd.read || cmd.mul || cmd.acc || cmd.emit))
        else $error("load accepted during a compute run");
`endif

endmodule

FILE: tb/matrix_multiply_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply_engine: load and compute beats in,
// product entries out. Depends on mme_pkg, mme_stream_if and the engine RTL.
module matrix_multiply_engine_tb;
    import mme_pkg::*;

    localparam int ROWS  = ROWS_DEFAULT;
    localparam int INNER = INNER_DEFAULT;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_PCT       = 32;
    localparam int QUIET_FIRST    = 120;
    localparam int QUIET_LAST     = 200;
    localparam int RANDOM_BEATS   = 224;
    localparam int SETTLE_CYCLES  = 300;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        in_item_t item;
        bit       drain;
    } feed_t;

    logic clk;
    logic rst_n;

    mme_stream_if #(.payload_t(in_item_t))  req_ch ();
    mme_stream_if #(.payload_t(out_item_t)) res_ch ();

    matrix_multiply_engine #(
        .ROWS  (ROWS),
        .INNER (INNER)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    // Shadow copies of the two operand stores.
    logic signed [ELEM_W-1:0] a_mem [ROWS][INNER];
    logic signed [ELEM_W-1:0] b_mem [INNER][ROWS];

    feed_t     feed_q[$];
    out_item_t product_q[$];

    int  beats_sent;
    int  runs_started;
    int  entries_checked;
    int  errors;
    bit  req_taken;
    wire calm = (beats_sent >= QUIET_FIRST) && (beats_sent < QUIET_LAST);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic predict_products();
        logic signed [ACC_W-1:0] sum;
        out_item_t entry;
        for (int i = 0; i < ROWS; i++)
        begin
            for (int j = 0; j < ROWS; j++)
            begin
                sum = '0;
                for (int k = 0; k < INNER; k++)
                begin
                    sum += a_mem[i][k] * b_mem[k][j];
                end
                entry.out_row       = IDX_W'(i);
                entry.out_column    = IDX_W'(j);
                entry.product_value = sum;
                entry.last          = (i == ROWS - 1) && (j == ROWS - 1);
                product_q.push_back(entry);
            end
        end
    endtask

    task automatic apply_request(input in_item_t it);
        case (it.func)
            FUNC_WRITE_A:
            begin
                if (it.row < ROWS && it.column < INNER)
                    a_mem[it.row][it.column] = it.element;
            end
            FUNC_WRITE_B:
            begin
                if (it.row < INNER && it.column < ROWS)
                    b_mem[it.row][it.column] = it.element;
            end
            FUNC_COMPUTE:
            begin
                runs_started++;
                predict_products();
            end
            default:
            begin
                // Unused function code: no state change and no result.
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic add_beat(input logic [FUNC_W-1:0] func, input int row, input int column,
                            input logic signed [ELEM_W-1:0] element);
        feed_t f;
        f.item.func    = func;
        f.item.row     = IDX_W'(row);
        f.item.column  = IDX_W'(column);
        f.item.element = element;
        f.drain        = 1'b0;
        feed_q.push_back(f);
    endtask

    task automatic add_drain();
        feed_t f;
        f.item  = '0;
        f.drain = 1'b1;
        feed_q.push_back(f);
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Request driver: a new beat is presented only once the previous one was taken.
    always @(negedge clk)
    begin : drive_requests
        logic     next_valid;
        in_item_t next_data;
        feed_t    head;
        next_valid = req_ch.valid && !req_taken;
        next_data  = req_ch.data;
        if (rst_n && !next_valid && feed_q.size() != 0)
        begin
            if (feed_q[0].drain)
            begin
                if (product_q.size() == 0)
                    void'(feed_q.pop_front());
            end
            else if (calm || $urandom_range(99) >= IDLE_PCT)
            begin
                head       = feed_q.pop_front();
                next_data  = head.item;
                next_valid = 1'b1;
                beats_sent++;
            end
        end
        req_ch.valid <= next_valid;
        req_ch.data  <= next_data;
    end

    always @(negedge clk)
    begin
        res_ch.ready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Result checker, then the prediction for whatever request beat was taken on this edge.
    always @(posedge clk)
    begin : watch_beats
        out_item_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (product_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t ns: unexpected product entry row %0d column %0d value %0d",
                                 $time, res_ch.data.out_row, res_ch.data.out_column,
                                 res_ch.data.product_value);
                end
                else
                begin
                    want = product_q.pop_front();
                    entries_checked++;
                    if (res_ch.data.out_row !== want.out_row)
                        note_mismatch("out_row", want.out_row, res_ch.data.out_row);
                    if (res_ch.data.out_column !== want.out_column)
                        note_mismatch("out_column", want.out_column, res_ch.data.out_column);
                    if (res_ch.data.product_value !== want.product_value)
                        note_mismatch("product_value", want.product_value,
                                      res_ch.data.product_value);
                    if (res_ch.data.last !== want.last)
                        note_mismatch("last", want.last, res_ch.data.last);
                end
            end
            if (req_ch.valid && req_ch.ready)
                apply_request(req_ch.data);
            req_taken <= req_ch.valid && req_ch.ready;
        end
        else
        begin
            req_taken <= 1'b0;
        end
    end

    initial
    begin
        #5_000_000;
        $display("matrix_multiply_engine_tb: errors");
        $finish;
    end

    initial
    begin
        int pick;
        int kind;
        rst_n           = 1'b0;
        req_taken       = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.data     = '0;
        res_ch.ready    = 1'b0;
        beats_sent      = 0;
        runs_started    = 0;
        entries_checked = 0;
        errors          = 0;

        // Both operands at the most negative value: every entry is the largest positive sum.
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < INNER; c++)
                add_beat(FUNC_WRITE_A, r, c, 16'sh8000);
        for (int r = 0; r < INNER; r++)
            for (int c = 0; c < ROWS; c++)
                add_beat(FUNC_WRITE_B, r, c, 16'sh8000);
        add_beat(FUNC_COMPUTE, 0, 0, '0);
        add_drain();
        // Mix in the largest positive value for the most negative sums.
        for (int c = 0; c < INNER; c++)
            add_beat(FUNC_WRITE_A, 0, c, 16'sh7FFF);
        for (int r = 0; r < INNER; r++)
            add_beat(FUNC_WRITE_B, r, ROWS - 1, 16'sh7FFF);
        // An unused function code must not touch the stores.
        add_beat(FUNC_UNUSED, 1, 1, 16'sh1234);
        add_beat(FUNC_UNUSED, 3, 3, 16'shFFFF);
        add_beat(FUNC_WRITE_B, INNER - 1, 0, 16'sh0001);
        // Compute with every ignored field set to ones.
        add_beat(FUNC_COMPUTE, 3, 3, 16'shFFFF);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                add_beat(FUNC_COMPUTE, $urandom_range(3), $urandom_range(3), ELEM_W'($urandom));
                if (n > RANDOM_BEATS / 2 && $urandom_range(3) == 0)
                    add_drain();
            end
            else if (pick < 13)
            begin
                add_beat(FUNC_UNUSED, $urandom_range(3), $urandom_range(3), ELEM_W'($urandom));
            end
            else
            begin
                kind = $urandom_range(1);
                if (kind == 0)
                    add_beat(FUNC_WRITE_A, $urandom_range(ROWS - 1), $urandom_range(INNER - 1),
                             pick_element());
                else
                    add_beat(FUNC_WRITE_B, $urandom_range(INNER - 1), $urandom_range(ROWS - 1),
                             pick_element());
            end
        end
        add_beat(FUNC_COMPUTE, 0, 0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || req_ch.valid || product_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d request beats and %0d compute runs; %0d product entries checked.",
                 beats_sent, runs_started, entries_checked);
        if (errors == 0)
            $display("matrix_multiply_engine_tb: clean");
        else
            $display("matrix_multiply_engine_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
src/mme_pkg.sv
src/mme_stream_if.sv
src/mme_ram.sv
src/mme_ctrl.sv
src/mme_datapath.sv
src/matrix_multiply_engine.sv
tb/matrix_multiply_engine_tb.sv
